### sv/wcd_pkg.sv
package wcd_pkg;

	localparam int MAX_DIM = 256;
	localparam int XW      = $clog2(MAX_DIM);
	localparam int ZW      = XW + 1;
	localparam int AW      = 2 * XW;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int REG_W   = 9;
	localparam int CW      = (ZW > REG_W) ? ZW : REG_W;
	localparam int IDX_W   = 2;
	localparam int SQ_W    = 26;
	localparam int SPLIT_W = 24;
	localparam int QCNT_W  = 2;

	localparam logic [IDX_W-1:0] CFG_DIM_X = 2'd0;
	localparam logic [IDX_W-1:0] CFG_DIM_Y = 2'd1;
	localparam logic [IDX_W-1:0] CFG_DIM_Z = 2'd2;

	localparam logic [REG_W-1:0]   DIM_RESET = 9'd256;
	localparam logic [SQ_W-1:0]    SQ_MAX    = '1;
	localparam logic [SPLIT_W-1:0] SPLIT_MAX = '1;

	localparam int unsigned AXIS_FLIP [3] = '{1, 2, 4};

	typedef struct packed {
		logic [SQ_W-1:0]    squares;
		logic [SPLIT_W-1:0] occ_split;
		logic [SPLIT_W-1:0] empty_split;
		logic               size_error;
	} result_t;

	function automatic logic [CW-1:0] eff_dim(input logic [REG_W-1:0] raw);
		logic [CW-1:0] v;
		v = CW'(raw);
		if (v == '0)
			return CW'(1);
		if (v > CW'(MAX_DIM))
			return CW'(MAX_DIM);
		return v;
	endfunction

	// swap corners along one axis of the 2x2x2 block
	function automatic logic [7:0] flip_mask(input logic [7:0] r, input int unsigned f);
		logic [7:0] o;
		for (int i = 0; i < 8; i++)
			o[i] = r[i ^ f];
		return o;
	endfunction

	// set corners form two or more face-connected groups
	function automatic logic split(input logic [7:0] m);
		logic [7:0] reach;
		reach = m & (~m + 8'd1);
		for (int it = 0; it < 7; it++)
			for (int k = 0; k < 3; k++)
				reach = reach | (flip_mask(reach, AXIS_FLIP[k]) & m);
		return (m != 8'd0) && (reach != m);
	endfunction

	function automatic logic is_checker(input logic a, input logic b, input logic c,
			input logic d);
		return (a == d) && (b == c) && (a != b);
	endfunction

endpackage

### sv/wcd_ifs.sv
interface wcd_in_if;
	logic valid;
	logic ready;
	logic voxel_occupied;
	logic last_voxel;

	modport source(output valid, output voxel_occupied, output last_voxel, input ready);
	modport sink(input valid, input voxel_occupied, input last_voxel, output ready);
endinterface

interface wcd_out_if;
	logic                       valid;
	logic                       ready;
	logic [wcd_pkg::SQ_W-1:0]    edge_checkerboard_count;
	logic [wcd_pkg::SPLIT_W-1:0] occupied_split_count;
	logic [wcd_pkg::SPLIT_W-1:0] empty_split_count;
	logic                       size_error;

	modport source(output valid, output edge_checkerboard_count, output occupied_split_count,
		output empty_split_count, output size_error, input ready);
	modport sink(input valid, input edge_checkerboard_count, input occupied_split_count,
		input empty_split_count, input size_error, output ready);
endinterface

### sv/well_composed_defect_counter.sv
// channel  dir  payload                                                     when
// voxel    in   voxel_occupied, last_voxel                                  valid & ready
// result   out  edge_checkerboard_count, occupied_split_count,              valid & ready
//               empty_split_count, size_error
// cfg      in   cfg_index, cfg_data                                         cfg_we
//
// One voxel per cycle while voxel.ready is high; a voxel's window tests and plane store write
// finish in the cycle after it is taken (the registered read of the two-port plane RAM).
// Results go through a two-word queue; voxel.ready drops only while the queue, less a
// word leaving this cycle, plus a pending last word reaches two.
// Reset clears positions, totals and extents (256); plane RAM contents are not cleared.
module well_composed_defect_counter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [wcd_pkg::IDX_W-1:0] cfg_index,
	input  logic [wcd_pkg::REG_W-1:0] cfg_data,
	wcd_in_if.sink                    voxel,
	wcd_out_if.source                 result
);
	import wcd_pkg::*;

	logic [REG_W-1:0] dim_x_q, dim_y_q, dim_z_q;
	logic [CW-1:0]    dx, dy, dz;

	logic [XW-1:0] pos_x_q, pos_y_q, nx, ny;
	logic [ZW-1:0] pos_z_q, nz;
	logic          ov_q, ov_next, active0, err0, wrap_x, wrap_y, fire;
	logic [AW-1:0] ra, rb;

	logic          s1_valid_q;
	logic          s1_occ_s1, s1_last_s1, s1_active_s1, s1_zpar_s1, s1_err_s1;
	logic          s1_xg_s1, s1_yg_s1, s1_zg_s1, s1_fwd_a_s1, s1_fwd_b_s1;
	logic [AW-1:0] s1_addr_s1;
	logic [1:0]    s1_wd_s1;

	logic [1:0]    rd_a, rd_b, word_a, word_b, wdata;
	logic          we;
	logic          a_prv, b_cur, b_prv;
	logic          h_occ_q, ha_prv_q, hb_cur_q, hb_prv_q;
	logic          sq_xy, sq_xz, sq_yz, blk;
	logic [1:0]    sq_inc;
	logic [7:0]    mask;

	logic [SQ_W-1:0]    sq_q, sq_new;
	logic [SPLIT_W-1:0] os_q, os_new, es_q, es_new;
	logic [SQ_W:0]      sq_sum;
	logic [SPLIT_W:0]   os_sum, es_sum;

	logic [QCNT_W-1:0] q_cnt;
	logic              pend;
	logic              pop_now;
	result_t           res;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DIM_RESET;
			dim_y_q <= DIM_RESET;
			dim_z_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIM_X: dim_x_q <= cfg_data;
				CFG_DIM_Y: dim_y_q <= cfg_data;
				CFG_DIM_Z: dim_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx = eff_dim(dim_x_q);
	assign dy = eff_dim(dim_y_q);
	assign dz = eff_dim(dim_z_q);

	// position stepping at accept
	assign fire    = voxel.valid && voxel.ready;
	assign active0 = CW'(pos_z_q) < dz;
	assign wrap_x  = (CW'(pos_x_q) + CW'(1)) >= dx;
	assign wrap_y  = (CW'(pos_y_q) + CW'(1)) >= dy;
	assign nx      = !active0 ? pos_x_q : (wrap_x ? '0 : pos_x_q + 1'b1);
	assign ny      = (!active0 || !wrap_x) ? pos_y_q : (wrap_y ? '0 : pos_y_q + 1'b1);
	assign nz      = (active0 && wrap_x && wrap_y) ? pos_z_q + 1'b1 : pos_z_q;
	assign ov_next = ov_q || !active0;
	assign err0    = ov_next || (CW'(nz) < dz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			ov_q    <= 1'b0;
		end else if (fire) begin
			if (voxel.last_voxel) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
				ov_q    <= 1'b0;
			end else begin
				pos_x_q <= nx;
				pos_y_q <= ny;
				pos_z_q <= nz;
				ov_q    <= ov_next;
			end
		end
	end

	// word (x,y) holds both plane parities; A = (x,y), B = (x,y-1)
	assign ra = {pos_y_q, pos_x_q};
	assign rb = {pos_y_q - 1'b1, pos_x_q};

	wcd_ram #(
		.WIDTH(2),
		.DEPTH(DEPTH)
	) u_plane (
		.clk    (clk),
		.we     (we),
		.waddr  (s1_addr_s1),
		.wdata  (wdata),
		.re     (fire),
		.raddr_a(ra),
		.raddr_b(rb),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else
			s1_valid_q <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			s1_occ_s1    <= voxel.voxel_occupied;
			s1_last_s1   <= voxel.last_voxel;
			s1_active_s1 <= active0;
			s1_zpar_s1   <= pos_z_q[0];
			s1_err_s1    <= err0;
			s1_xg_s1     <= (pos_x_q != '0);
			s1_yg_s1     <= (pos_y_q != '0);
			s1_zg_s1     <= (pos_z_q != '0);
			s1_addr_s1   <= ra;
			// write of the word in flight lands after this read
			s1_fwd_a_s1  <= we && (ra == s1_addr_s1);
			s1_fwd_b_s1  <= we && (rb == s1_addr_s1);
			s1_wd_s1     <= wdata;
		end
	end

	// window evaluation and write-back
	assign word_a = s1_fwd_a_s1 ? s1_wd_s1 : rd_a;
	assign word_b = s1_fwd_b_s1 ? s1_wd_s1 : rd_b;
	assign a_prv  = word_a[!s1_zpar_s1];
	assign b_cur  = word_b[s1_zpar_s1];
	assign b_prv  = word_b[!s1_zpar_s1];

	assign we = s1_valid_q && s1_active_s1;

	always_comb begin
		wdata              = word_a;
		wdata[s1_zpar_s1]  = s1_occ_s1;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			h_occ_q  <= s1_occ_s1;
			ha_prv_q <= a_prv;
			hb_cur_q <= b_cur;
			hb_prv_q <= b_prv;
		end
	end

	assign sq_xy = s1_xg_s1 && s1_yg_s1 && is_checker(hb_cur_q, b_cur, h_occ_q, s1_occ_s1);
	assign sq_xz = s1_xg_s1 && s1_zg_s1 && is_checker(ha_prv_q, a_prv, h_occ_q, s1_occ_s1);
	assign sq_yz = s1_yg_s1 && s1_zg_s1 && is_checker(b_prv, a_prv, b_cur, s1_occ_s1);
	assign sq_inc = 2'(sq_xy) + 2'(sq_xz) + 2'(sq_yz);
	assign blk    = s1_xg_s1 && s1_yg_s1 && s1_zg_s1;
	assign mask   = {s1_occ_s1, h_occ_q, b_cur, hb_cur_q, a_prv, ha_prv_q, b_prv, hb_prv_q};

	assign sq_sum = {1'b0, sq_q} + (SQ_W + 1)'(sq_inc);
	assign os_sum = {1'b0, os_q} + (SPLIT_W + 1)'(blk && split(mask));
	assign es_sum = {1'b0, es_q} + (SPLIT_W + 1)'(blk && split(~mask));

	assign sq_new = !s1_active_s1 ? sq_q : (sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0]);
	assign os_new = !s1_active_s1 ? os_q : (os_sum[SPLIT_W] ? SPLIT_MAX : os_sum[SPLIT_W-1:0]);
	assign es_new = !s1_active_s1 ? es_q : (es_sum[SPLIT_W] ? SPLIT_MAX : es_sum[SPLIT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= '0;
			os_q <= '0;
			es_q <= '0;
		end else if (s1_valid_q) begin
			if (s1_last_s1) begin
				sq_q <= '0;
				os_q <= '0;
				es_q <= '0;
			end else begin
				sq_q <= sq_new;
				os_q <= os_new;
				es_q <= es_new;
			end
		end
	end

	// result queue
	assign res.squares     = sq_new;
	assign res.occ_split   = os_new;
	assign res.empty_split = es_new;
	assign res.size_error  = s1_err_s1;

	assign pend = s1_valid_q && s1_last_s1;

	wcd_result_q u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (pend),
		.push_data(res),
		.count    (q_cnt),
		.result   (result)
	);

	assign pop_now     = (q_cnt != '0) && result.ready;
	assign voxel.ready = ({1'b0, q_cnt} + (QCNT_W + 1)'(pend)) <
		((QCNT_W + 1)'(2) + (QCNT_W + 1)'(pop_now));

endmodule

### sv/wcd_ram.sv
module wcd_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### sv/wcd_result_q.sv
module wcd_result_q (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  wcd_pkg::result_t         push_data,
	output logic [wcd_pkg::QCNT_W-1:0] count,
	wcd_out_if.source                result
);
	import wcd_pkg::*;

	result_t               head_q;
	result_t               tail_q;
	logic [QCNT_W-1:0]     cnt_q;
	logic                  pop;

	assign pop   = result.valid && result.ready;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == '0)
				head_q <= push_data;
			else
				tail_q <= push_data;
		end else if (pop && !push) begin
			head_q <= tail_q;
		end else if (pop && push) begin
			if (cnt_q == QCNT_W'(1)) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
				tail_q <= push_data;
			end
		end
	end

	assign result.valid                   = (cnt_q != '0);
	assign result.edge_checkerboard_count = head_q.squares;
	assign result.occupied_split_count    = head_q.occ_split;
	assign result.empty_split_count       = head_q.empty_split;
	assign result.size_error              = head_q.size_error;

endmodule

### verif/well_composed_defect_counter_test.sv
module well_composed_defect_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wcd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [REG_W-1:0]   cfg_data;

	wcd_in_if  voxel_ch ();
	wcd_out_if result_ch ();

	well_composed_defect_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.voxel(voxel_ch),
		.result(result_ch)
	);

	// predictor state
	bit                 plane_bits [2][MAX_DIM][MAX_DIM];
	logic [REG_W-1:0]   ext_reg [3];
	int unsigned        px, py, pz;
	logic [SQ_W-1:0]    square_cnt;
	logic [SPLIT_W-1:0] occ_split_cnt;
	logic [SPLIT_W-1:0] empty_split_cnt;
	bit                 past_end;
	result_t            expected_totals [$];

	int  mismatches = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;
	bit  stall_on = 1'b1;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int unsigned clamp_extent(input logic [REG_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (raw > MAX_DIM)
			return MAX_DIM;
		return 32'(raw);
	endfunction

	function automatic int unsigned volume_items();
		return clamp_extent(ext_reg[CFG_DIM_X]) * clamp_extent(ext_reg[CFG_DIM_Y]) *
			clamp_extent(ext_reg[CFG_DIM_Z]);
	endfunction

	function automatic bit stored(input int unsigned z, input int unsigned x,
			input int unsigned y);
		return plane_bits[z & 1][y][x];
	endfunction

	function automatic bit checkerboard(input bit a, input bit b, input bit c, input bit d);
		return (a == d) && (b == c) && (a != b);
	endfunction

	// flood fill from the lowest set corner; neighbors differ in one index bit
	function automatic bit corners_split(input logic [7:0] m);
		logic [7:0] grown;
		grown = '0;
		for (int i = 7; i >= 0; i--)
			if (m[i])
				grown = 8'd1 << i;
		for (int round = 0; round < 7; round++)
			for (int i = 0; i < 8; i++)
				if (grown[i]) begin
					grown[i ^ 1] = grown[i ^ 1] | m[i ^ 1];
					grown[i ^ 2] = grown[i ^ 2] | m[i ^ 2];
					grown[i ^ 4] = grown[i ^ 4] | m[i ^ 4];
				end
		return (m != '0) && (grown != m);
	endfunction

	function automatic void clear_volume();
		px = 0;
		py = 0;
		pz = 0;
		square_cnt = '0;
		occ_split_cnt = '0;
		empty_split_cnt = '0;
		past_end = 1'b0;
	endfunction

	function automatic void predict_voxel(input bit occ, input bit last);
		int unsigned ex, ey, ez, x, y, z;
		logic [7:0] corners;
		result_t totals;
		ex = clamp_extent(ext_reg[CFG_DIM_X]);
		ey = clamp_extent(ext_reg[CFG_DIM_Y]);
		ez = clamp_extent(ext_reg[CFG_DIM_Z]);
		if (pz >= ez) begin
			past_end = 1'b1;
		end else begin
			x = px;
			y = py;
			z = pz;
			plane_bits[z & 1][y][x] = occ;
			if (x > 0 && y > 0 && square_cnt != SQ_MAX &&
					checkerboard(stored(z, x - 1, y - 1), stored(z, x, y - 1),
					stored(z, x - 1, y), occ))
				square_cnt++;
			if (x > 0 && z > 0 && square_cnt != SQ_MAX &&
					checkerboard(stored(z - 1, x - 1, y), stored(z - 1, x, y),
					stored(z, x - 1, y), occ))
				square_cnt++;
			if (y > 0 && z > 0 && square_cnt != SQ_MAX &&
					checkerboard(stored(z - 1, x, y - 1), stored(z - 1, x, y),
					stored(z, x, y - 1), occ))
				square_cnt++;
			if (x > 0 && y > 0 && z > 0) begin
				for (int k = 0; k < 8; k++)
					corners[k] = stored(z - 1 + ((k >> 2) & 1), x - 1 + (k & 1),
						y - 1 + ((k >> 1) & 1));
				if (corners_split(corners) && occ_split_cnt != SPLIT_MAX)
					occ_split_cnt++;
				if (corners_split(~corners) && empty_split_cnt != SPLIT_MAX)
					empty_split_cnt++;
			end
			x++;
			if (x >= ex) begin
				x = 0;
				y++;
				if (y >= ey) begin
					y = 0;
					z++;
				end
			end
			px = x;
			py = y;
			pz = z;
		end
		if (last) begin
			totals.squares = square_cnt;
			totals.occ_split = occ_split_cnt;
			totals.empty_split = empty_split_cnt;
			totals.size_error = past_end || (pz < ez);
			expected_totals.push_back(totals);
			clear_volume();
		end
	endfunction

	function automatic void compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: result word with none expected");
			end else begin
				want = expected_totals.pop_front();
				compare_field("edge_checkerboard_count", 32'(want.squares),
					32'(result_ch.edge_checkerboard_count));
				compare_field("occupied_split_count", 32'(want.occ_split),
					32'(result_ch.occupied_split_count));
				compare_field("empty_split_count", 32'(want.empty_split),
					32'(result_ch.empty_split_count));
				compare_field("size_error", 32'(want.size_error),
					32'(result_ch.size_error));
			end
		end
	end

	always begin : result_sink
		@(posedge clk);
		if (stall_on && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		result_ch.ready <= 1'b1;
	end

	// valid stays high after a word is taken; whoever waits next lowers it
	task automatic send_voxel(input bit occ, input bit last);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			voxel_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		voxel_ch.valid <= 1'b1;
		voxel_ch.voxel_occupied <= occ;
		voxel_ch.last_voxel <= last;
		do @(posedge clk); while (voxel_ch.ready !== 1'b1);
		predict_voxel(occ, last);
	endtask

	task automatic drain_results();
		voxel_ch.valid <= 1'b0;
		while (expected_totals.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_extent(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		ext_reg[idx] = val;
	endtask

	task automatic set_extents(input logic [REG_W-1:0] ex, input logic [REG_W-1:0] ey,
			input logic [REG_W-1:0] ez);
		drain_results();
		write_extent(CFG_DIM_X, ex);
		write_extent(CFG_DIM_Y, ey);
		write_extent(CFG_DIM_Z, ez);
		cfg_we <= 1'b0;
	endtask

	// corner k of a 2x2x2 volume is item k
	task automatic send_bits(input logic [7:0] bits, input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_voxel(bits[i], i == n - 1);
	endtask

	task automatic send_random_volume(input int unsigned n);
		int unsigned fill;
		case ($urandom_range(0, 6))
			0: fill = 0;
			1: fill = 100;
			2: fill = 25;
			3: fill = 75;
			default: fill = 50;
		endcase
		for (int unsigned i = 0; i < n; i++)
			send_voxel($urandom_range(1, 100) <= fill, i == n - 1);
	endtask

	function automatic logic [REG_W-1:0] pick_extent();
		if ($urandom_range(0, 9) == 0)
			return '0;
		return REG_W'($urandom_range(1, 4));
	endfunction

	task automatic test_reset_extents();
		// one word against a 256-cube: short volume, error set
		send_voxel(1'b1, 1'b1);
	endtask

	task automatic test_window_patterns();
		set_extents(9'd2, 9'd2, 9'd2);
		send_bits(8'h69, 8);  // 3D checkerboard: six squares, both splits
		send_bits(8'h81, 8);  // opposite corners only
	endtask

	task automatic test_short_volume();
		send_bits(8'h02, 2);
	endtask

	task automatic test_overflow_volume();
		set_extents(9'd2, 9'd1, 9'd1);
		send_bits(8'h05, 3);
	endtask

	task automatic test_extent_extremes();
		set_extents(9'd511, 9'd0, 9'd2);
		send_random_volume(volume_items());
		set_extents(9'd1, 9'd256, 9'd1);
		send_random_volume(volume_items());
		set_extents(9'd1, 9'd1, 9'd256);
		send_random_volume(volume_items());
	endtask

	task automatic test_random_volumes();
		int unsigned sent, vols, n;
		sent = 0;
		vols = 0;
		while (sent < 600 || vols < 40) begin
			if (vols % 4 == 0)
				set_extents(pick_extent(), pick_extent(), pick_extent());
			idle_on = $urandom_range(0, 3) != 0;
			stall_on = $urandom_range(0, 3) != 0;
			n = volume_items();
			case ($urandom_range(0, 9))
				0: n = $urandom_range(1, n);
				1: n = n + $urandom_range(1, 4);
				default: ;
			endcase
			send_random_volume(n);
			sent += n;
			vols++;
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end
	endtask

	task automatic test_back_to_back();
		set_extents(9'd3, 9'd3, 9'd2);
		idle_on = 1'b0;
		stall_on = 1'b0;
		repeat (10) send_random_volume(volume_items());
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DIM_X;
		cfg_data <= '0;
		voxel_ch.valid <= 1'b0;
		voxel_ch.voxel_occupied <= 1'b0;
		voxel_ch.last_voxel <= 1'b0;
		result_ch.ready <= 1'b0;
		for (int i = 0; i < 3; i++)
			ext_reg[i] = DIM_RESET;
		clear_volume();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_extents();
		test_window_patterns();
		test_short_volume();
		test_overflow_volume();
		test_extent_extremes();
		test_random_volumes();
		test_back_to_back();

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_totals.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
sv/wcd_pkg.sv
sv/wcd_ifs.sv
sv/wcd_ram.sv
sv/wcd_result_q.sv
sv/well_composed_defect_counter.sv
verif/well_composed_defect_counter_test.sv
